// ----- rtl/sgdw_pkg.sv -----
// Shared types and constants for the averaged SGD weight updater.
// No dependencies; the controller, datapath, top level and testbench refer to it by scoped names.
package sgdw_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_ALPHA    = 3'd0,
    CFG_RATE_OFFSET   = 3'd1,
    CFG_CONSTANT_RATE = 3'd2,
    CFG_NUM_WEIGHTS   = 3'd3,
    CFG_NUM_SAMPLES   = 3'd4,
    CFG_MAX_EPOCHS    = 3'd5
  } cfg_idx_t;

  // Field and counter widths.
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned NW_W     = 11;
  localparam int unsigned NS_W     = 16;
  localparam int unsigned EPOCH_W  = 10;
  localparam int unsigned ITER_W   = 32;
  localparam int unsigned ETA_W    = 17;
  localparam int unsigned FRAC_W   = 16;
  // Width of s = t*2^16 + t0 and of the 2^48 dividend.
  localparam int unsigned ETA_DIV_W = 49;
  localparam int unsigned ETA_NUM_SHIFT = 48;

  // Step size of one, in Q1.16.
  localparam logic [ETA_W-1:0] ETA_ONE = 17'h10000;

  // Reset values of the configuration registers.
  localparam logic [NW_W-1:0]    NW_RESET    = 11'd1024;
  localparam logic [NS_W-1:0]    NS_RESET    = 16'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_RESET = 10'd50;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 10'd1023;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the input item
    logic clr_step;   // write one zero entry of the average store
    logic rd;         // read both stores at the item index
    logic begin_item; // latch read data, do a load, advance t
    logic eta_one;    // set step size to one
    logic div1_go;    // start 2^48 / alpha
    logic div2_go;    // start quotient / s
    logic eta_set;    // take the clamped quotient as step size
    logic mul;        // register eta * gradient
    logic upd;        // write the updated weight
    logic avg_go;     // start |w| / num_samples
    logic avg_wr;     // write the updated average
    logic finish;     // advance the sample and epoch counts
    logic out_load;   // put the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // clearing pass at its last entry
    logic update;      // item is a gradient that applies
    logic idx_zero;    // item starts a sample
    logic eta_special; // alpha or s is zero
    logic averaging;   // last epoch is running
    logic div_done;    // divider finished this cycle
    logic out_free;    // output register can take a result
  } status_t;

endpackage

// ----- rtl/sgdw_if.sv -----
// Handshake channels of the SGD weight updater: input items and result items.
// Depends on nothing; widths come from the instantiating level, but for the 17-bit rate_out.
interface sgdw_in_if #(
  parameter int unsigned VW = 32,
  parameter int unsigned IW = 10
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [IW-1:0]        weight_index;
  logic signed [VW-1:0] element_value;

  modport source (output valid, mode, weight_index, element_value, input ready);
  modport sink (input valid, mode, weight_index, element_value, output ready);
endinterface

interface sgdw_out_if #(
  parameter int unsigned VW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] weight_out;
  logic signed [VW-1:0] average_out;
  logic [16:0]          rate_out;
  logic                 last_epoch;
  logic                 finished;

  modport source (output valid, weight_out, average_out, rate_out, last_epoch, finished,
                  input ready);
  modport sink (input valid, weight_out, average_out, rate_out, last_epoch, finished,
                output ready);
endinterface

// ----- rtl/sgdw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgdw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sgdw_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; the caller guarantees a nonzero divisor.
module sgdw_div #(
  parameter int unsigned W = 49
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W:0]    rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    rem_sh;
  logic          fits;

  assign rem_sh = {rem[W-1:0], quotient[W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  // Shift in one dividend bit a cycle and subtract where the divisor fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CW'(W);
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
        quotient <= {quotient[W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/sgdw_ctrl.sv -----
// Sequencer of the SGD weight updater: clearing pass, then one item at a time.
// Depends on sgdw_pkg for the command and status structs.
module sgdw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sgdw_pkg::status_t st,
  output sgdw_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_ETA0, S_ETA_A, S_ETA_B,
    S_MUL, S_UPD, S_AVG_GO, S_AVG, S_WRAP, S_HOLD
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Commands and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.begin_item = 1'b1;
        if (st.update && st.idx_zero) state_next = S_ETA0;
        else if (st.update)           state_next = S_MUL;
        else                          state_next = S_WRAP;
      end
      S_ETA0: begin
        if (st.eta_special) begin
          cmd.eta_one = 1'b1;
          state_next  = S_MUL;
        end else begin
          cmd.div1_go = 1'b1;
          state_next  = S_ETA_A;
        end
      end
      S_ETA_A: begin
        if (st.div_done) begin
          cmd.div2_go = 1'b1;
          state_next  = S_ETA_B;
        end
      end
      S_ETA_B: begin
        if (st.div_done) begin
          cmd.eta_set = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = st.averaging ? S_AVG_GO : S_WRAP;
      end
      S_AVG_GO: begin
        cmd.avg_go = 1'b1;
        state_next = S_AVG;
      end
      S_AVG: begin
        if (st.div_done) begin
          cmd.avg_wr = 1'b1;
          state_next = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.finish = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/sgdw_datapath.sv -----
// Datapath of the SGD weight updater: registers, stores, divider, multiply, output.
// Depends on sgdw_pkg, sgdw_ram and sgdw_div.
module sgdw_datapath #(
  parameter int unsigned MAX_WEIGHTS = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned IW          = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sgdw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgdw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_mode,
  input  logic [IW-1:0]                       in_index,
  input  logic signed [VALUE_WIDTH-1:0]       in_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [VALUE_WIDTH-1:0]       out_weight,
  output logic signed [VALUE_WIDTH-1:0]       out_average,
  output logic [sgdw_pkg::ETA_W-1:0]          out_rate,
  output logic                                out_last,
  output logic                                out_finished,
  input  sgdw_pkg::cmd_t                      cmd,
  output sgdw_pkg::status_t                   st
);

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned DW  = (VW > sgdw_pkg::ETA_DIV_W) ? VW : sgdw_pkg::ETA_DIV_W;
  localparam int unsigned XW  = 17; // index compares, holds MAX_WEIGHTS itself
  localparam logic [XW-1:0] MAXW = XW'(MAX_WEIGHTS);
  localparam int unsigned PW  = VW + 18;
  localparam int unsigned QW  = VW + 2;
  localparam int unsigned WSW = VW + 3;
  localparam int unsigned ASW = DW + 2;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // Configuration registers.
  logic [sgdw_pkg::RATE_W-1:0]  alpha, offset;
  logic                         crate;
  logic [sgdw_pkg::NW_W-1:0]    nw_cfg;
  logic [sgdw_pkg::NS_W-1:0]    ns_cfg;
  logic [sgdw_pkg::EPOCH_W-1:0] max_ep;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha  <= '0;
      offset <= '0;
      crate  <= 1'b0;
      nw_cfg <= sgdw_pkg::NW_RESET;
      ns_cfg <= sgdw_pkg::NS_RESET;
      max_ep <= sgdw_pkg::EPOCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgdw_pkg::CFG_RATE_ALPHA:    alpha  <= cfg_data;
        sgdw_pkg::CFG_RATE_OFFSET:   offset <= cfg_data;
        sgdw_pkg::CFG_CONSTANT_RATE: crate  <= cfg_data[0];
        sgdw_pkg::CFG_NUM_WEIGHTS:   nw_cfg <= cfg_data[sgdw_pkg::NW_W-1:0];
        sgdw_pkg::CFG_NUM_SAMPLES:   ns_cfg <= cfg_data[sgdw_pkg::NS_W-1:0];
        sgdw_pkg::CFG_MAX_EPOCHS:    max_ep <= cfg_data[sgdw_pkg::EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective vector length and sample count.
  logic [XW-1:0]             nw_eff;
  logic [sgdw_pkg::NS_W-1:0] ns_eff;
  always_comb begin
    if (nw_cfg == '0)                 nw_eff = XW'(1);
    else if (XW'(nw_cfg) > MAXW)      nw_eff = MAXW;
    else                              nw_eff = XW'(nw_cfg);
    ns_eff = (ns_cfg == '0) ? sgdw_pkg::NS_W'(1) : ns_cfg;
  end

  // Captured item.
  logic                 mode_r;
  logic [IW-1:0]        idx_r;
  logic signed [VW-1:0] val_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      idx_r  <= in_index;
      val_r  <= in_value;
    end
  end

  // Training counters.
  logic [sgdw_pkg::ITER_W-1:0]  iter;
  logic [sgdw_pkg::NS_W-1:0]    samp;
  logic [sgdw_pkg::EPOCH_W-1:0] epoch;
  logic [sgdw_pkg::ETA_W-1:0]   eta;
  logic                         done_now, last_now, idx_ok, update, end_sample;
  logic [sgdw_pkg::NS_W-1:0]    samp_inc;

  assign done_now   = epoch >= max_ep;
  assign last_now   = ({1'b0, epoch} + 1'b1) == {1'b0, max_ep};
  assign idx_ok     = XW'(idx_r) < MAXW;
  assign update     = mode_r && !done_now && idx_ok && (XW'(idx_r) < nw_eff);
  assign end_sample = XW'(idx_r) == nw_eff - 1'b1;
  assign samp_inc   = samp + 1'b1;

  // Step size denominator s = t*2^16 + t0, or t0 alone.
  logic [sgdw_pkg::ETA_DIV_W-1:0] s_val;
  assign s_val = crate ? sgdw_pkg::ETA_DIV_W'(offset)
                       : sgdw_pkg::ETA_DIV_W'({iter, {sgdw_pkg::FRAC_W{1'b0}}})
                         + sgdw_pkg::ETA_DIV_W'(offset);

  // Shared divider for the step size and the averaging term.
  logic          div_go, div_done;
  logic [DW-1:0] div_num, div_den, div_q;
  logic signed [VW-1:0] w_r, a_r;
  logic [VW-1:0] w_mag;
  logic          w_neg;

  assign w_neg  = w_r[VW-1];
  assign w_mag  = w_neg ? VW'(-w_r) : VW'(w_r);
  assign div_go = cmd.div1_go || cmd.div2_go || cmd.avg_go;

  always_comb begin
    priority if (cmd.div1_go) begin
      div_num = DW'(1) << sgdw_pkg::ETA_NUM_SHIFT;
      div_den = DW'(alpha);
    end else if (cmd.div2_go) begin
      div_num = div_q;
      div_den = DW'(s_val);
    end else begin
      div_num = DW'(w_mag);
      div_den = DW'(ns_eff);
    end
  end

  sgdw_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Weight and average stores.
  logic [VW-1:0]        w_rd, a_rd;
  logic                 w_we, a_we;
  logic [IW-1:0]        clr_cnt, a_waddr;
  logic [VW-1:0]        w_wdata, a_wdata;
  logic signed [VW-1:0] w_new, a_new;

  assign w_we    = (cmd.begin_item && !mode_r && idx_ok) || cmd.upd;
  assign w_wdata = cmd.upd ? w_new : val_r;
  assign a_we    = cmd.clr_step || cmd.avg_wr;
  assign a_waddr = cmd.clr_step ? clr_cnt : idx_r;
  assign a_wdata = cmd.clr_step ? '0 : a_new;

  sgdw_ram #(.WIDTH(VW), .DEPTH(MAX_WEIGHTS), .AW(IW)) u_wram (
    .clk (clk), .we (w_we), .waddr (idx_r), .wdata (w_wdata),
    .re (cmd.rd), .raddr (idx_r), .rdata (w_rd)
  );

  sgdw_ram #(.WIDTH(VW), .DEPTH(MAX_WEIGHTS), .AW(IW)) u_aram (
    .clk (clk), .we (a_we), .waddr (a_waddr), .wdata (a_wdata),
    .re (cmd.rd), .raddr (idx_r), .rdata (a_rd)
  );

  // Weight update: w - floor(eta*g / 2^16), saturated.
  logic signed [PW-1:0]  prod;
  logic signed [QW-1:0]  q_step;
  logic signed [WSW-1:0] w_diff;
  assign q_step = prod[PW-1:16];
  assign w_diff = WSW'(w_r) - WSW'(q_step);
  always_comb begin
    if (&w_diff[WSW-1:VW-1] || ~|w_diff[WSW-1:VW-1]) w_new = w_diff[VW-1:0];
    else                                             w_new = w_diff[WSW-1] ? VMIN : VMAX;
  end

  // Average update: a + trunc(w / num_samples), saturated.
  logic signed [DW:0]    avg_d;
  logic signed [ASW-1:0] a_sum;
  assign avg_d = w_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign a_sum = ASW'(a_r) + ASW'(avg_d);
  always_comb begin
    if (&a_sum[ASW-1:VW-1] || ~|a_sum[ASW-1:VW-1]) a_new = a_sum[VW-1:0];
    else                                           a_new = a_sum[ASW-1] ? VMIN : VMAX;
  end

  // Item registers, counters and clearing pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      iter    <= '0;
      samp    <= '0;
      epoch   <= '0;
      eta     <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.begin_item && update && idx_r == '0) iter <= iter + 1'b1;
      if (cmd.eta_one) eta <= sgdw_pkg::ETA_ONE;
      if (cmd.eta_set) begin
        eta <= (div_q > DW'(sgdw_pkg::ETA_ONE)) ? sgdw_pkg::ETA_ONE
                                                 : div_q[sgdw_pkg::ETA_W-1:0];
      end
      if (cmd.finish && update && end_sample) begin
        if (samp_inc >= ns_eff || samp_inc == '0) begin
          samp <= '0;
          if (epoch != sgdw_pkg::EPOCH_MAX) epoch <= epoch + 1'b1;
        end else begin
          samp <= samp_inc;
        end
      end
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk) begin
    if (cmd.begin_item) begin
      if (!idx_ok) begin
        w_r <= '0;
        a_r <= '0;
      end else begin
        w_r <= mode_r ? $signed(w_rd) : val_r;
        a_r <= $signed(a_rd);
      end
    end
    if (cmd.mul)    prod <= $signed({1'b0, eta}) * val_r;
    if (cmd.upd)    w_r  <= w_new;
    if (cmd.avg_wr) a_r  <= a_new;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_weight   <= w_r;
      out_average  <= a_r;
      out_rate     <= eta;
      out_last     <= last_now;
      out_finished <= done_now;
    end
  end

  // Status to the controller.
  always_comb begin
    st             = '0;
    st.clr_last    = clr_cnt == IW'(MAX_WEIGHTS - 1);
    st.update      = update;
    st.idx_zero    = idx_r == '0;
    st.eta_special = (alpha == '0) || (s_val == '0);
    st.averaging   = last_now;
    st.div_done    = div_done;
    st.out_free    = !out_valid || out_ready;
  end

endmodule

// ----- rtl/sgd_weight_update.sv -----
// Top level of the averaged SGD weight updater: controller plus datapath.
// Depends on sgdw_pkg, sgdw_if, sgdw_ram, sgdw_div, sgdw_ctrl and sgdw_datapath.
//
//  Channel  Dir  Handshake          Payload
//  in_ch    in   valid / ready      mode, weight_index, element_value
//  out_ch   out  valid / ready      weight_out, average_out, rate_out, last_epoch, finished
//  cfg      in   cfg_we             cfg_index, cfg_data
//
// After reset the average store is zeroed, one entry a cycle, with no input item accepted
// until the clearing pass ends. One item is worked on at a time. A load or an ignored item
// goes through read, decide, wrap and hold; a gradient element adds a multiply and an
// update; in the last epoch an averaging division follows the update (the bit-serial divider
// is max(49, VALUE_WIDTH) bits wide), and element 0 of a sample first gets its step size
// from two divisions (from neither when alpha or s is zero). The output register lets
// the next item be accepted while a result waits on a stalled sink.
module sgd_weight_update #(
  parameter int unsigned MAX_WEIGHTS = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sgdw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgdw_pkg::CFG_DATA_W-1:0] cfg_data,
  sgdw_in_if.sink                         in_ch,
  sgdw_out_if.source                      out_ch
);

  localparam int unsigned IW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;

  sgdw_pkg::cmd_t    cmd;
  sgdw_pkg::status_t st;

  // Sequencer.
  sgdw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  sgdw_datapath #(
    .MAX_WEIGHTS (MAX_WEIGHTS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IW          (IW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mode      (in_ch.mode),
    .in_index     (in_ch.weight_index),
    .in_value     (in_ch.element_value),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_weight   (out_ch.weight_out),
    .out_average  (out_ch.average_out),
    .out_rate     (out_ch.rate_out),
    .out_last     (out_ch.last_epoch),
    .out_finished (out_ch.finished),
    .cmd          (cmd),
    .st           (st)
  );

  // One item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in work");

  // The step size never exceeds one.
  a_rate_limit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.rate_out <= sgdw_pkg::ETA_ONE))
    else $error("step size above one");

  // The last epoch and the finished state exclude each other.
  a_phase: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.last_epoch && out_ch.finished))
    else $error("last epoch and finished both set");

endmodule

// ----- tb/sv/sgd_weight_update_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sgd_weight_update: random and directed weight loads and
// gradient samples, with a built-in predictor of the weights, averages and step size.
// Depends on sgdw_pkg, the sgdw_in_if / sgdw_out_if channels and the block's RTL.
module sgd_weight_update_test;

  localparam bit MODE_LOAD = 1'b0;
  localparam bit MODE_GRAD = 1'b1;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;
  // Entries loaded up front; every gradient index stays below this one.
  localparam int LOADED = 64;

  typedef struct {
    bit               mode;
    logic [9:0]       index;
    logic signed [31:0] value;
  } update_item_t;

  typedef struct {
    logic signed [31:0] weight;
    logic signed [31:0] average;
    logic [16:0]        rate;
    logic               last_ep;
    logic               done;
  } update_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [sgdw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sgdw_pkg::CFG_DATA_W-1:0] cfg_data;

  sgdw_in_if #(.VW(32), .IW(10)) in_ch ();
  sgdw_out_if #(.VW(32)) out_ch ();

  sgd_weight_update dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  update_item_t   pending_items[$];
  update_result_t expected_results[$];
  int mismatches = 0;
  bit in_taken = 1'b0;
  bit calm = 1'b0;

  // Predictor state and its copy of the configuration.
  logic signed [31:0] weights [1024];
  logic signed [31:0] averages [1024];
  logic [31:0] iter_count;
  logic [15:0] sample_count;
  logic [9:0]  epoch_count;
  logic [16:0] step_size;
  logic [31:0] alpha_reg, offset_reg;
  logic        const_reg;
  logic [10:0] nw_reg;
  logic [15:0] ns_reg;
  logic [9:0]  epochs_reg;

  function automatic longint clamp_value(longint v);
    return v > VAL_MAX ? VAL_MAX : (v < VAL_MIN ? VAL_MIN : v);
  endfunction

  function automatic int unsigned active_length();
    return nw_reg == 0 ? 1 : (nw_reg > 1024 ? 1024 : nw_reg);
  endfunction

  // Step size: 2^48 / alpha / s, limited to one; one when alpha or s is zero.
  function automatic logic [16:0] step_for_sample();
    logic [48:0] s;
    logic [63:0] e;
    s = const_reg ? {17'd0, offset_reg} : ({1'b0, iter_count, 16'd0} + offset_reg);
    if (alpha_reg == 0 || s == 0) return sgdw_pkg::ETA_ONE;
    e = ((64'd1 << 48) / alpha_reg) / s;
    return e > 64'd65536 ? sgdw_pkg::ETA_ONE : e[16:0];
  endfunction

  // Applies one item to the predicted state and returns the result it causes.
  function automatic update_result_t apply_item(update_item_t it);
    update_result_t r;
    int unsigned nw_eff, ns_eff;
    bit is_done;
    bit is_last;
    longint p, q;
    nw_eff = active_length();
    ns_eff = ns_reg == 0 ? 1 : ns_reg;
    is_done = int'(epoch_count) >= int'(epochs_reg);
    is_last = int'(epoch_count) + 1 == int'(epochs_reg);
    if (it.mode == MODE_LOAD) begin
      weights[it.index] = it.value;
    end else if (!is_done && it.index < nw_eff) begin
      if (it.index == 0) begin
        iter_count = iter_count + 1;
        step_size = step_for_sample();
      end
      p = longint'(step_size) * longint'(it.value);
      q = p >>> 16;
      weights[it.index] = clamp_value(longint'(weights[it.index]) - q);
      if (is_last)
        averages[it.index] = clamp_value(longint'(averages[it.index])
                                         + longint'(weights[it.index]) / longint'(ns_eff));
      if (it.index == nw_eff - 1) begin
        sample_count = sample_count + 1;
        if (sample_count >= ns_eff || sample_count == 0) begin
          sample_count = 0;
          if (epoch_count < 10'd1023) epoch_count = epoch_count + 1;
        end
      end
    end
    r.weight = weights[it.index];
    r.average = averages[it.index];
    r.rate = step_size;
    r.last_ep = int'(epoch_count) + 1 == int'(epochs_reg);
    r.done = int'(epoch_count) >= int'(epochs_reg);
    return r;
  endfunction

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.weight_index = '0;
    in_ch.element_value = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: presents the next pending item once the current one is taken.
  always @(negedge clk) begin
    update_item_t it;
    if (!rst) begin
      if (!in_ch.valid || in_taken) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
          it = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= it.mode;
          in_ch.weight_index <= it.index;
          in_ch.element_value <= it.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= calm || $urandom_range(99) >= 28;
    end
  end

  // Monitor: predicts on each accepted item and checks each accepted result.
  always @(posedge clk) begin
    update_item_t it;
    update_result_t want;
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      it.mode = in_ch.mode;
      it.index = in_ch.weight_index;
      it.value = in_ch.element_value;
      expected_results.push_back(apply_item(it));
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result item with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_ch.weight_out !== want.weight || out_ch.average_out !== want.average ||
            out_ch.rate_out !== want.rate || out_ch.last_epoch !== want.last_ep ||
            out_ch.finished !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: weight %h/%h average %h/%h rate %h/%h last %b/%b done %b/%b",
                     want.weight, out_ch.weight_out, want.average, out_ch.average_out,
                     want.rate, out_ch.rate_out, want.last_ep, out_ch.last_epoch,
                     want.done, out_ch.finished);
        end
      end
    end
  end

  task automatic push_item(bit m, int unsigned idx, logic [31:0] v);
    update_item_t it;
    it.mode = m;
    it.index = idx[9:0];
    it.value = v;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom) >>> 20);
      default: return 32'($signed($urandom) >>> 12);
    endcase
  endfunction

  // Waits until every item is taken and every result has arrived.
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(sgdw_pkg::cfg_idx_t i, logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (i)
      sgdw_pkg::CFG_RATE_ALPHA:    alpha_reg = d;
      sgdw_pkg::CFG_RATE_OFFSET:   offset_reg = d;
      sgdw_pkg::CFG_CONSTANT_RATE: const_reg = d[0];
      sgdw_pkg::CFG_NUM_WEIGHTS:   nw_reg = d[10:0];
      sgdw_pkg::CFG_NUM_SAMPLES:   ns_reg = d[15:0];
      sgdw_pkg::CFG_MAX_EPOCHS:    epochs_reg = d[9:0];
      default: ;
    endcase
  endtask

  // One setting: mostly whole samples, some stray loads and out-of-order gradients.
  task automatic run_setting(logic [31:0] alpha, logic [31:0] offset, bit cr,
                             logic [10:0] nw, logic [15:0] ns, int extra_epochs, int count);
    int made;
    int r;
    int top;
    write_reg(sgdw_pkg::CFG_RATE_ALPHA, alpha);
    write_reg(sgdw_pkg::CFG_RATE_OFFSET, offset);
    write_reg(sgdw_pkg::CFG_CONSTANT_RATE, {31'd0, cr});
    write_reg(sgdw_pkg::CFG_NUM_WEIGHTS, {21'd0, nw});
    write_reg(sgdw_pkg::CFG_NUM_SAMPLES, {16'd0, ns});
    top = int'(epoch_count) + extra_epochs;
    write_reg(sgdw_pkg::CFG_MAX_EPOCHS, top > 1023 ? 32'd1023 : 32'(top));
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 78) begin
        for (int j = 0; j < int'(active_length()) && made < count; j++) begin
          push_item(MODE_GRAD, j, random_value());
          made++;
        end
      end else if (r < 90) begin
        push_item(MODE_LOAD, $urandom_range(LOADED - 1), random_value());
        made++;
      end else begin
        push_item(MODE_GRAD, $urandom_range(LOADED - 1), random_value());
        made++;
      end
    end
    drain();
  endtask

  // Stimulus.
  initial begin
    alpha_reg = 0; offset_reg = 0; const_reg = 0;
    nw_reg = sgdw_pkg::NW_RESET; ns_reg = sgdw_pkg::NS_RESET;
    epochs_reg = sgdw_pkg::EPOCH_RESET;
    iter_count = 0; sample_count = 0; epoch_count = 0; step_size = 0;
    foreach (weights[i]) weights[i] = 0;
    foreach (averages[i]) averages[i] = 0;
    @(negedge rst);

    // The low entries are loaded first so that no gradient finds an unwritten entry.
    for (int i = 0; i < LOADED; i++) push_item(MODE_LOAD, i, 32'($signed($urandom) >>> 14));
    drain();

    // Directed: a step size of one against extreme gradients, ignored indexes and loads.
    write_reg(sgdw_pkg::CFG_NUM_WEIGHTS, 32'd3);
    write_reg(sgdw_pkg::CFG_NUM_SAMPLES, 32'd2);
    write_reg(sgdw_pkg::CFG_MAX_EPOCHS, 32'd2);
    push_item(MODE_GRAD, 0, 32'h80000000);
    push_item(MODE_GRAD, 1, 32'h7FFFFFFF);
    push_item(MODE_GRAD, 2, 32'h00000000);
    push_item(MODE_GRAD, 7, 32'h00010000);
    push_item(MODE_LOAD, 1, 32'h7FFFFFFF);
    push_item(MODE_LOAD, 1023, 32'h80000000);
    push_item(MODE_LOAD, 0, 32'h80000000);
    push_item(MODE_GRAD, 0, 32'h7FFFFFFF);
    push_item(MODE_GRAD, 1, 32'hFFFFFFFF);
    push_item(MODE_GRAD, 2, 32'h00000001);
    for (int s = 0; s < 2; s++)
      for (int j = 0; j < 3; j++) push_item(MODE_GRAD, j, 32'hFFFF0000);
    push_item(MODE_GRAD, 0, 32'h00020000);
    push_item(MODE_LOAD, 512, 32'h12345678);
    drain();

    // Random settings, the register extremes among them.
    run_setting(32'h00010000, 32'h00010000, 1'b0, 11'd4, 16'd3, 3, 120);
    run_setting(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 11'd2, 16'd1, 2, 100);
    run_setting($urandom, 32'd0, 1'b1, 11'd5, 16'd2, 3, 150);
    run_setting(32'h00008000, 32'h00040000, 1'b1, 11'd3, 16'd0, 4, 150);
    run_setting($urandom_range(32'h40000), $urandom, 1'b0, 11'd1, 16'd5, 3, 150);
    run_setting(32'h00020000, 32'h00001000, 1'b0, 11'd0, 16'd2, 2, 100);
    run_setting(32'h00010000, 32'h00010000, 1'b0, 11'd2047, 16'd1, 1, 30);
    run_setting(32'h00001000, 32'h00000100, 1'b0, 11'd1024, 16'd65535, 1, 20);
    run_setting(32'h00004000, 32'h00100000, 1'b0, 11'd3, 16'd1, 1023, 50);
    run_setting(32'h00010000, 32'h00010000, 1'b0, 11'd2, 16'd1, 0, 30);
    write_reg(sgdw_pkg::CFG_MAX_EPOCHS, 32'd0);
    run_setting($urandom, $urandom, 1'b0, 11'd3, 16'd1, 0, 20);
    calm = 1'b1;
    run_setting($urandom_range(32'h30000), $urandom_range(32'h80000), 1'b0, 11'd6, 16'd2,
                3, 120);
    calm = 1'b0;

    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
